// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion macros for the calendar adder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package cas_pkg;

   localparam int DivWidth   = 33;               // widest dividend: second + add count
   localparam int DivrWidth  = 6;                // divisors 60 and 24
   localparam int DaysWidth  = 16;               // whole days left to walk
   localparam int WsumWidth  = 13;

   localparam logic [DivrWidth-1:0] Sixty   = 6'd60;
   localparam logic [DivrWidth-1:0] Hours24 = 6'd24;

   // x/60 = (x/4)/15 and x/24 = (x/8)/3, both exact for 32-bit scaled x
   localparam logic [31:0] Recip15 = 32'h8888_8889;   // ceil(2^35 / 15)
   localparam logic [31:0] Recip3  = 32'hAAAA_AAAB;   // ceil(2^33 / 3)

   localparam logic [2:0] WdOffset [12] = '{3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
                                            3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4};
   localparam logic [4:0] MonthLen [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   typedef struct packed {
      logic                 start;
      logic [DivrWidth-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // y mod 25 == 0, by reciprocal 1311/2^15 (exact for 12-bit years)
   function automatic logic div25(input logic [11:0] y);
      logic [22:0] prod;
      logic [7:0]  q;
      logic [11:0] back;
      prod = 23'(y) * 23'd1311;
      q    = prod[22:15];
      back = 12'(q) * 12'd25;
      return (back == y);
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'd0) && (!div25(y) || (y[3:0] == 4'd0));
   endfunction

   function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] len;
      len = 5'd31;
      if (m >= 4'd1 && m <= 4'd12) begin
         len = MonthLen[m - 4'd1];
      end
      if (m == 4'd2 && is_leap(y)) begin
         len = 5'd29;
      end
      return len;
   endfunction

   // Sakamoto sum before the mod 7 step; a/400 taken as (a/100)/4
   function automatic logic [WsumWidth-1:0] wday_sum(input logic [11:0] y,
                                                     input logic [3:0]  m,
                                                     input logic [4:0]  d);
      logic [12:0] a;
      logic [25:0] prod;
      logic [5:0]  q100;
      logic [2:0]  off;
      a    = 13'(y) + 13'd400 - ((m < 4'd3) ? 13'd1 : 13'd0);
      prod = 26'(a) * 26'd5243;
      q100 = prod[24:19];
      off  = 3'd0;
      if (m >= 4'd1 && m <= 4'd12) begin
         off = WdOffset[m - 4'd1];
      end
      return a + 13'(a[12:2]) - 13'(q100) + 13'(q100[5:2]) + 13'(off) + 13'(d);
   endfunction

   // s mod 7 by reciprocal 9363/2^16 (exact below 2^13)
   function automatic logic [2:0] mod7(input logic [WsumWidth-1:0] s);
      logic [26:0] prod;
      logic [10:0] q;
      logic [12:0] back;
      prod = 27'(s) * 27'd9363;
      q    = prod[26:16];
      back = 13'(q) * 13'd7;
      return 3'(s - back);
   endfunction

endpackage

// ===== hdl/calendar_add_seconds.sv =====
// ----------------------------------------------------------------------------
// calendar_add_seconds
// Advances a Gregorian date/time by a 32-bit second count; gives weekday.
// ----------------------------------------------------------------------------
// Flow: a range check, then three passes of a shared reciprocal divider for the
//   time carry, then a day walk of one month per cycle and the weekday sum and
//   mod 7 step; a bad date answers straight from the range check.
// Throughput: one item at a time, busy until the strobe.
// Reset: synchronous, returns to idle; rsp_valid is a one-cycle strobe
//   that the receiver cannot stall.
`include "assert_macros.svh"

module calendar_add_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic [31:0] req_add_seconds,
   output logic        rsp_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday,
   output logic        rsp_bad_input
);
   import cas_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,      // range check of month and day
      ST_DIV_SEC,    // (second + add) / 60
      ST_DIV_MIN,    // (minute + carry) / 60
      ST_DIV_HOUR,   // (hour + carry) / 24 -> whole days
      ST_WALK,       // one month per cycle
      ST_WD_SUM,     // Sakamoto sum
      ST_WD_MOD      // mod 7, deliver item
   } state_type;

   state_type state_ff, state_in;

   // working date/time
   logic [11:0]          yr_ff, yr_in;
   logic [3:0]           mo_ff, mo_in;
   logic [4:0]           dy_ff, dy_in;
   logic [4:0]           hr_ff, hr_in;
   logic [5:0]           mi_ff, mi_in;
   logic [5:0]           se_ff, se_in;
   logic [31:0]          add_ff, add_in;
   logic [DaysWidth-1:0] left_ff, left_in;
   logic [WsumWidth-1:0] wsum_ff, wsum_in;

   // result registers
   logic        rvalid_ff, rvalid_in;
   logic [11:0] ryr_ff, ryr_in;
   logic [3:0]  rmo_ff, rmo_in;
   logic [4:0]  rdy_ff, rdy_in;
   logic [4:0]  rhr_ff, rhr_in;
   logic [5:0]  rmi_ff, rmi_in;
   logic [5:0]  rse_ff, rse_in;
   logic [2:0]  rwd_ff, rwd_in;
   logic        rbad_ff, rbad_in;

   // shared divider
   div_cmd_type          div_cmd;
   div_sts_type          div_sts;
   logic [DivWidth-1:0]  div_dividend;
   logic [DivWidth-1:0]  div_quot;
   logic [DivrWidth-1:0] div_rem;

   logic [4:0] dim;
   logic [4:0] rem_days;
   logic       bad;
   logic       in_div;
   logic       walk_day_ok;

   cas_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .sts       (div_sts),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      dim      = month_days(yr_ff, mo_ff);
      rem_days = dim - dy_ff;
      bad      = (mo_ff == 4'd0) || (mo_ff > 4'd12) || (dy_ff == 5'd0) || (dy_ff > dim);

      state_in = state_ff;
      yr_in    = yr_ff;
      mo_in    = mo_ff;
      dy_in    = dy_ff;
      hr_in    = hr_ff;
      mi_in    = mi_ff;
      se_in    = se_ff;
      add_in   = add_ff;
      left_in  = left_ff;
      wsum_in  = wsum_ff;

      rvalid_in = 1'b0;
      ryr_in    = ryr_ff;
      rmo_in    = rmo_ff;
      rdy_in    = rdy_ff;
      rhr_in    = rhr_ff;
      rmi_in    = rmi_ff;
      rse_in    = rse_ff;
      rwd_in    = rwd_ff;
      rbad_in   = rbad_ff;

      div_cmd.start   = 1'b0;
      div_cmd.divisor = Sixty;
      div_dividend    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               yr_in    = req_year;
               mo_in    = req_month;
               dy_in    = req_day;
               hr_in    = req_hour;
               mi_in    = req_minute;
               se_in    = req_second;
               add_in   = req_add_seconds;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (bad) begin
               // date echoes through unchanged, weekday meaningless
               rvalid_in = 1'b1;
               ryr_in    = yr_ff;
               rmo_in    = mo_ff;
               rdy_in    = dy_ff;
               rhr_in    = hr_ff;
               rmi_in    = mi_ff;
               rse_in    = se_ff;
               rwd_in    = 3'd0;
               rbad_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               div_cmd.start   = 1'b1;
               div_cmd.divisor = Sixty;
               div_dividend    = DivWidth'(se_ff) + DivWidth'(add_ff);
               state_in        = ST_DIV_SEC;
            end
         end
         ST_DIV_SEC: begin
            if (div_sts.done) begin
               se_in           = div_rem;
               div_cmd.start   = 1'b1;
               div_cmd.divisor = Sixty;
               div_dividend    = DivWidth'(mi_ff) + div_quot;
               state_in        = ST_DIV_MIN;
            end
         end
         ST_DIV_MIN: begin
            if (div_sts.done) begin
               mi_in           = div_rem;
               div_cmd.start   = 1'b1;
               div_cmd.divisor = Hours24;
               div_dividend    = DivWidth'(hr_ff) + div_quot;
               state_in        = ST_DIV_HOUR;
            end
         end
         ST_DIV_HOUR: begin
            if (div_sts.done) begin
               hr_in    = div_rem[4:0];
               left_in  = div_quot[DaysWidth-1:0];
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (left_ff <= DaysWidth'(rem_days)) begin
               // remaining days fit in this month
               dy_in    = dy_ff + left_ff[4:0];
               state_in = ST_WD_SUM;
            end else begin
               left_in = left_ff - DaysWidth'(rem_days) - DaysWidth'(1);
               dy_in   = 5'd1;
               if (mo_ff == 4'd12) begin
                  mo_in = 4'd1;
                  yr_in = yr_ff + 12'd1;   // 4095 wraps to 0
               end else begin
                  mo_in = mo_ff + 4'd1;
               end
            end
         end
         ST_WD_SUM: begin
            wsum_in  = wday_sum(yr_ff, mo_ff, dy_ff);
            state_in = ST_WD_MOD;
         end
         ST_WD_MOD: begin
            rvalid_in = 1'b1;
            ryr_in    = yr_ff;
            rmo_in    = mo_ff;
            rdy_in    = dy_ff;
            rhr_in    = hr_ff;
            rmi_in    = mi_ff;
            rse_in    = se_ff;
            rwd_in    = mod7(wsum_ff) + 3'd1;
            rbad_in   = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      yr_ff   <= yr_in;
      mo_ff   <= mo_in;
      dy_ff   <= dy_in;
      hr_ff   <= hr_in;
      mi_ff   <= mi_in;
      se_ff   <= se_in;
      add_ff  <= add_in;
      left_ff <= left_in;
      wsum_ff <= wsum_in;
      ryr_ff  <= ryr_in;
      rmo_ff  <= rmo_in;
      rdy_ff  <= rdy_in;
      rhr_ff  <= rhr_in;
      rmi_ff  <= rmi_in;
      rse_ff  <= rse_in;
      rwd_ff  <= rwd_in;
      rbad_ff <= rbad_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rvalid_ff;
   assign rsp_year      = ryr_ff;
   assign rsp_month     = rmo_ff;
   assign rsp_day       = rdy_ff;
   assign rsp_hour      = rhr_ff;
   assign rsp_minute    = rmi_ff;
   assign rsp_second    = rse_ff;
   assign rsp_weekday   = rwd_ff;
   assign rsp_bad_input = rbad_ff;

   // divider may only run during the three carry passes
   assign in_div      = (state_ff == ST_DIV_SEC) || (state_ff == ST_DIV_MIN) ||
                        (state_ff == ST_DIV_HOUR);
   assign walk_day_ok = (dy_ff != 5'd0) && (dy_ff <= dim);

   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "item not taken")
   `ASSERT_IMPLIES(a_div_state, clock, reset, div_sts.done || div_sts.busy, in_div, "divider out of step")
   `ASSERT_IMPLIES(a_walk_day, clock, reset, state_ff == ST_WALK, walk_day_ok, "walk day out of month")

endmodule

// ===== hdl/cas_div.sv =====
// ----------------------------------------------------------------------------
// cas_div
// Shared divide-by-60/24 unit: reciprocal multiply, then remainder fix-up.
// A pass loads, multiplies, then registers quotient and remainder with done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cas_div (
   input  logic                          clock,
   input  logic                          reset,
   input  cas_pkg::div_cmd_type          cmd,
   input  logic [cas_pkg::DivWidth-1:0]  dividend,
   output cas_pkg::div_sts_type          sts,
   output logic [cas_pkg::DivWidth-1:0]  quotient,
   output logic [cas_pkg::DivrWidth-1:0] remainder
);
   import cas_pkg::*;

   logic [DivWidth-1:0]  num_ff, num_in;
   logic [DivrWidth-1:0] dvr_ff, dvr_in;
   logic [63:0]          prod_ff, prod_in;
   logic [DivWidth-1:0]  quot_ff, quot_in;
   logic [DivrWidth-1:0] rem_ff, rem_in;
   logic                 phase_ff, phase_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 by24;
   logic [31:0]          scaled;
   logic [31:0]          recip;
   logic [DivWidth-1:0]  q;
   logic [11:0]          qd_low;

   always_comb begin
      by24   = (dvr_ff == Hours24);
      // pre-shift by the power-of-two factor of the divisor
      scaled = by24 ? 32'(num_ff[DivWidth-1:3]) : 32'(num_ff[DivWidth-1:2]);
      recip  = by24 ? Recip3 : Recip15;
      q      = by24 ? DivWidth'(prod_ff[63:33]) : DivWidth'(prod_ff[63:35]);
      // remainder is below 64, so six bits of x - q*d are enough
      qd_low = 12'(q[5:0]) * 12'(dvr_ff);

      num_in   = num_ff;
      dvr_in   = dvr_ff;
      prod_in  = prod_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         num_in   = dividend;
         dvr_in   = cmd.divisor;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            prod_in  = 64'(scaled) * 64'(recip);
            phase_in = 1'b1;
         end else begin
            quot_in = q;
            rem_in  = num_ff[DivrWidth-1:0] - qd_low[DivrWidth-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      dvr_ff  <= dvr_in;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (reset) begin
         phase_ff <= 1'b0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   `ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "divider done held")
   `ASSERT_IMPLIES(a_done_idle, clock, reset, done_ff, !busy_ff, "done while busy")

endmodule

// ===== tb/calendar_add_seconds_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_add_seconds_checker
// Watches the request and result channels of the calendar adder, predicts
// each result on its own and compares it field by field with what the block
// gives.
// ----------------------------------------------------------------------------

module calendar_add_seconds_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic [31:0] req_add_seconds,
   input  logic        rsp_valid,
   input  logic [11:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   input  logic [2:0]  rsp_weekday,
   input  logic        rsp_bad_input,
   output int          mismatches,
   output int          pending,
   output int          checked,
   output int          bad_dates
);

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic        bad;
   } date_time_type;

   date_time_type expected_dates[$];
   date_time_type seen;
   date_time_type want;
   int            error_count   = 0;
   int            results_count = 0;
   int            flagged_count = 0;

   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
         2:         return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:   return 31;
      endcase
   endfunction

   // Sakamoto key per month, January first
   function automatic int unsigned month_key(int unsigned m);
      case (m)
         1, 5:   return 0;
         2, 6:   return 3;
         3, 11:  return 2;
         4:      return 5;
         7:      return 5;
         8:      return 1;
         9:      return 4;
         10:     return 6;
         default: return 4;
      endcase
   endfunction

   function automatic date_time_type advance_clock(logic [11:0] y, logic [3:0] mo,
                                                   logic [4:0] d, logic [4:0] h,
                                                   logic [5:0] mi, logic [5:0] s,
                                                   logic [31:0] add);
      date_time_type   r;
      logic [32:0]     sec_sum;
      longint unsigned total_min;
      longint unsigned total_hr;
      longint unsigned days_left;
      int unsigned     yr;
      int unsigned     mon;
      int unsigned     dy;
      int unsigned     room;
      int unsigned     a;
      r = '{year: y, month: mo, day: d, hour: h, minute: mi, second: s,
            weekday: 3'd0, bad: 1'b0};
      if (mo < 1 || mo > 12 || d == 0 || d > month_length(y, mo)) begin
         // bad date: echo the inputs, weekday zero
         r.bad = 1'b1;
         return r;
      end
      sec_sum   = 33'(s) + 33'(add);
      total_min = longint'(mi) + sec_sum / 60;
      total_hr  = longint'(h) + total_min / 60;
      days_left = total_hr / 24;
      r.second  = 6'(sec_sum % 60);
      r.minute  = 6'(total_min % 60);
      r.hour    = 5'(total_hr % 24);
      yr  = y;
      mon = mo;
      dy  = d;
      while (days_left > 0) begin
         room = month_length(yr, mon) - dy;
         if (days_left <= room) begin
            dy        = dy + int'(days_left);
            days_left = 0;
         end else begin
            days_left = days_left - room - 1;
            dy        = 1;
            mon++;
            if (mon > 12) begin
               mon = 1;
               yr  = (yr + 1) % 4096;
            end
         end
      end
      a = yr + 400 - ((mon < 3) ? 1 : 0);
      r.year    = 12'(yr);
      r.month   = 4'(mon);
      r.day     = 5'(dy);
      r.weekday = 3'((a + a / 4 - a / 100 + a / 400 + month_key(mon) + dy) % 7 + 1);
      return r;
   endfunction

   function automatic string format_stamp(date_time_type t);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd %0d bad %0b", t.year, t.month,
                       t.day, t.hour, t.minute, t.second, t.weekday, t.bad);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            seen = '{year: rsp_year, month: rsp_month, day: rsp_day, hour: rsp_hour,
                     minute: rsp_minute, second: rsp_second, weekday: rsp_weekday,
                     bad: rsp_bad_input};
            if (expected_dates.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result with no item pending: %s", $realtime,
                           format_stamp(seen));
            end else begin
               want = expected_dates.pop_front();
               results_count++;
               if (seen.year !== want.year || seen.month !== want.month ||
                   seen.day !== want.day || seen.hour !== want.hour ||
                   seen.minute !== want.minute || seen.second !== want.second ||
                   seen.weekday !== want.weekday || seen.bad !== want.bad) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: mismatch, expected %s, got %s", $realtime,
                              format_stamp(want), format_stamp(seen));
               end
            end
         end
         if (start && !busy) begin
            want = advance_clock(req_year, req_month, req_day, req_hour, req_minute,
                                 req_second, req_add_seconds);
            if (want.bad) flagged_count++;
            expected_dates.push_back(want);
         end
      end
      mismatches <= error_count;
      pending    <= expected_dates.size();
      checked    <= results_count;
      bad_dates  <= flagged_count;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives date/time items into calendar_add_seconds: a directed set of leap,
// century, rollover and bad-date cases, then random items with random idle
// gaps. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;

   // 304 items, each at the longest day walk plus the longest idle gap,
   // fit well inside this limit.
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 280;
   // the wait on pending covers every answer;
   // this drain only needs to catch a stray extra strobe
   localparam int DRAIN_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [11:0] req_year        = '0;
   logic [3:0]  req_month       = '0;
   logic [4:0]  req_day         = '0;
   logic [4:0]  req_hour        = '0;
   logic [5:0]  req_minute      = '0;
   logic [5:0]  req_second      = '0;
   logic [31:0] req_add_seconds = '0;
   logic        rsp_valid;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;
   logic        rsp_bad_input;

   int mismatches;
   int pending;
   int checked;
   int bad_dates;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;   // items still to go back to back, no idling

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   calendar_add_seconds i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_hour        (req_hour),
      .req_minute      (req_minute),
      .req_second      (req_second),
      .req_add_seconds (req_add_seconds),
      .rsp_valid       (rsp_valid),
      .rsp_year        (rsp_year),
      .rsp_month       (rsp_month),
      .rsp_day         (rsp_day),
      .rsp_hour        (rsp_hour),
      .rsp_minute      (rsp_minute),
      .rsp_second      (rsp_second),
      .rsp_weekday     (rsp_weekday),
      .rsp_bad_input   (rsp_bad_input)
   );

   calendar_add_seconds_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_hour        (req_hour),
      .req_minute      (req_minute),
      .req_second      (req_second),
      .req_add_seconds (req_add_seconds),
      .rsp_valid       (rsp_valid),
      .rsp_year        (rsp_year),
      .rsp_month       (rsp_month),
      .rsp_day         (rsp_day),
      .rsp_hour        (rsp_hour),
      .rsp_minute      (rsp_minute),
      .rsp_second      (rsp_second),
      .rsp_weekday     (rsp_weekday),
      .rsp_bad_input   (rsp_bad_input),
      .mismatches      (mismatches),
      .pending         (pending),
      .checked         (checked),
      .bad_dates       (bad_dates)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
         $display("** calendar_add_seconds: FAILED **");
         $finish;
      end
   end

   // Last day of a month for building legal (or just-illegal) dates.
   function automatic int unsigned month_end(int unsigned y, int unsigned m);
      case (m)
         2: return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // Present one item and hold it until the block takes it (start high, busy
   // low at an edge). Called in the time step of a rising edge; returns in the
   // step of the accepting edge, or later if an idle gap follows.
   task automatic issue_request(input logic [11:0] y, input logic [3:0] mo,
                                input logic [4:0] d, input logic [4:0] h,
                                input logic [5:0] mi, input logic [5:0] s,
                                input logic [31:0] add);
      int gap;
      int roll;
      req_year        <= y;
      req_month       <= mo;
      req_day         <= d;
      req_hour        <= h;
      req_minute      <= mi;
      req_second      <= s;
      req_add_seconds <= add;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;

      // Sender idling: short gaps that land inside the block's busy time,
      // mid-length ones that end at different points of the divider passes
      // or the day walk, a few long ones that can leave the block idle, and
      // occasional bursts with no gap at all.
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 10)
            burst_left = $urandom_range(4, 16);
         else if (roll < 55)
            gap = $urandom_range(1, 4);
         else if (roll < 90)
            gap = $urandom_range(5, 150);
         else
            gap = $urandom_range(151, 2000);
      end
      if (gap > 0) begin
         // junk on the request fields while start is low must be ignored
         start           <= 1'b0;
         req_year        <= 12'($urandom);
         req_month       <= 4'($urandom);
         req_day         <= 5'($urandom);
         req_hour        <= 5'($urandom);
         req_minute      <= 6'($urandom);
         req_second      <= 6'($urandom);
         req_add_seconds <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [11:0] yr;
      logic [3:0]  mo;
      logic [4:0]  dy;
      logic [4:0]  hr;
      logic [5:0]  mi;
      logic [5:0]  se;
      logic [31:0] add;
      int          pick;
      int          span;
      int          shape;
      int          directed_items;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed items ----
      // no advance at all
      issue_request(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0);
      // largest count from the last second of the nominal range
      issue_request(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'hFFFF_FFFF);
      // into Feb 29 and out of it in a leap year
      issue_request(12'd2024, 4'd2, 5'd28, 5'd12, 6'd0, 6'd0, 32'd86400);
      issue_request(12'd2024, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 32'd86400);
      // common year skips Feb 29
      issue_request(12'd2023, 4'd2, 5'd28, 5'd6, 6'd30, 6'd15, 32'd86400);
      // divisible by 400: leap
      issue_request(12'd2000, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0, 32'd86400);
      // divisible by 100 only: not leap
      issue_request(12'd2100, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0, 32'd86400);
      // year below 2000 is taken as given
      issue_request(12'd1900, 4'd2, 5'd28, 5'd23, 6'd0, 6'd0, 32'd3600);
      // December rolls into a new year
      issue_request(12'd2023, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd1);
      // 12-bit year wraps from 4095 to 0
      issue_request(12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd1);
      // year 0 is a leap year, weekday with January/February shift
      issue_request(12'd0, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0, 32'd86400);
      // wrap in the middle of a long walk; then Feb 28 of 4095 (common) and 4000 (leap)
      issue_request(12'd4090, 4'd6, 5'd15, 5'd8, 6'd30, 6'd0, 32'hFFFF_FFFF);
      issue_request(12'd4095, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0, 32'd86400);
      issue_request(12'd4000, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0, 32'd86400);
      // bad months: zero, thirteen, all ones
      issue_request(12'd2020, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3, 32'd1000);
      issue_request(12'd2020, 4'd13, 5'd10, 5'd1, 6'd2, 6'd3, 32'd1000);
      issue_request(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF);
      // bad days: zero, April 31, Feb 29 of a common year, Feb 30
      issue_request(12'd2020, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0);
      issue_request(12'd2023, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 32'd60);
      issue_request(12'd2023, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 32'd60);
      issue_request(12'd2024, 4'd2, 5'd30, 5'd0, 6'd0, 6'd0, 32'd60);
      // hour/minute/second past their range still carry
      issue_request(12'd2030, 4'd3, 5'd31, 5'd31, 6'd63, 6'd63, 32'd0);
      issue_request(12'd2010, 4'd5, 5'd20, 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF);
      // a single second carry into the minute
      issue_request(12'd2050, 4'd7, 5'd4, 5'd10, 6'd0, 6'd1, 32'd59);
      directed_items = items_sent;

      // ---- random items ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            yr = 12'($urandom_range(2000, 2099));
         else if (pick < 70)
            yr = 12'($urandom_range(4085, 4095));   // near the year wrap
         else
            yr = 12'($urandom_range(0, 4095));
         mo = 4'($urandom_range(1, 12));
         dy = 5'($urandom_range(1, month_end(yr, mo)));
         hr = 5'($urandom_range(0, 23));
         mi = 6'($urandom_range(0, 59));
         se = 6'($urandom_range(0, 59));
         if ($urandom_range(0, 9) == 0) begin
            // time fields over their nominal range
            hr = 5'($urandom_range(0, 31));
            mi = 6'($urandom_range(0, 63));
            se = 6'($urandom_range(0, 63));
         end
         // mostly short walks; only a fifth run the full count
         span = $urandom_range(0, 99);
         if (span < 30)
            add = $urandom_range(0, 200000);
         else if (span < 55)
            add = $urandom_range(0, 32'h00FF_FFFF);
         else if (span < 80)
            add = $urandom_range(0, 32'h0FFF_FFFF);
         else
            add = $urandom;

         shape = $urandom_range(0, 99);
         if (shape < 12) begin
            // last minute of a month: carries across day, month, year
            dy  = 5'(month_end(yr, mo));
            hr  = 5'd23;
            mi  = 6'd59;
            add = $urandom_range(0, 120);
         end else if (shape < 18) begin
            // one past the month end (day 0 for 31-day months)
            dy = (month_end(yr, mo) == 31) ? 5'd0 : 5'(month_end(yr, mo) + 1);
         end else if (shape < 30) begin
            // raw bits on every field
            yr  = 12'($urandom);
            mo  = 4'($urandom);
            dy  = 5'($urandom);
            hr  = 5'($urandom);
            mi  = 6'($urandom);
            se  = 6'($urandom);
            add = $urandom;
         end
         issue_request(yr, mo, dy, hr, mi, se, add);
      end

      // ---- drain and verdict ----
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent (%0d directed, %0d random), %0d results checked",
               items_sent, directed_items, items_sent - directed_items, checked);
      $display("%0d bad dates flagged, %0d mismatches, %0d cycles",
               bad_dates, mismatches, cycle_count);
      if (mismatches == 0 && pending == 0) begin
         $display("** calendar_add_seconds: PASSED **");
      end else begin
         $display("** calendar_add_seconds: FAILED **");
      end
      $finish;
   end

endmodule
